@@ rtl/ofdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofdc_pkg: shared constants and types for the oscillator control word block
// Widths, octave thresholds and fine-code scaling for the divider pipeline.
// ----------------------------------------------------------------------------
package ofdc_pkg;

	// Input and output field widths
	localparam int FREQ_BITS = 27;
	localparam int OCT_BITS  = 4;
	localparam int DAC_BITS  = 10;
	localparam int CW_BITS   = 16;
	localparam int CW_PAD    = 2;

	// Octave selection: largest k with OCT_BASE * 2^k <= f, k in 0..OCT_MAX
	localparam int OCT_BASE   = 1039;
	localparam int OCT_BASE_W = 11;
	localparam int OCT_MAX    = 15;
	localparam int OCT_CNT    = OCT_MAX + 1;
	localparam int THR_W      = (FREQ_BITS > OCT_BASE_W + OCT_CNT) ?
		FREQ_BITS : OCT_BASE_W + OCT_CNT;

	// Fine code: dac = DAC_CENTER - floor((2N + f) / (2f)), N = DAC_SCALE << (10 + oct)
	localparam int DAC_CENTER = 2048;
	localparam int DAC_SCALE  = 2078;
	localparam int DAC_MAX    = 1023;
	localparam int DAC_MIN_Q  = DAC_CENTER - DAC_MAX;
	localparam int NUM_SHIFT  = 11;

	// Divider geometry
	localparam int Q_BITS      = 12;
	localparam int BITS_PER_ST = 2;
	localparam int DIV_ST      = Q_BITS / BITS_PER_ST;
	localparam int NUM_W       = ((FREQ_BITS > 37) ? FREQ_BITS : 37) + 2;
	localparam int DEN_W       = FREQ_BITS + 1;
	localparam int CMP_W       = (NUM_W > DEN_W + Q_BITS) ? NUM_W : DEN_W + Q_BITS;

	typedef logic [FREQ_BITS-1:0] freq_t;
	typedef logic [OCT_BITS-1:0]  oct_t;
	typedef logic [DAC_BITS-1:0]  dac_t;
	typedef logic [NUM_W-1:0]     num_t;
	typedef logic [DEN_W-1:0]     den_t;
	typedef logic [Q_BITS-1:0]    quo_t;
	typedef logic [CMP_W-1:0]     cmp_t;

endpackage
`default_nettype wire

@@ rtl/osc_freq_to_octave_dac_code.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osc_freq_to_octave_dac_code: frequency to oscillator control word
// Picks the octave, divides the scaled octave constant by the frequency with
// a pipelined restoring divider, rounds and clamps the fine code, and packs
// octave and fine code into the control word.
// ----------------------------------------------------------------------------
// Pipeline: nine register stages: octave select, numerator build, six divider
//   stages of two quotient bits each, output register.
// Throughput: one item per cycle while the output is not stalled; each stage
//   advances on its own ready, so bubbles close up when the output stalls.
// Reset: arst_n clears all valid bits asynchronously; payload is not reset.
module osc_freq_to_octave_dac_code (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [ofdc_pkg::FREQ_BITS-1:0] freq_hz,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [ofdc_pkg::OCT_BITS-1:0]  octave,
	output logic [ofdc_pkg::DAC_BITS-1:0]  dac_code,
	output logic [ofdc_pkg::CW_BITS-1:0]   control_word,
	output logic                           clamped
);
	import ofdc_pkg::*;

	// Stage 1: octave select
	logic              valid_s1;
	freq_t             freq_s1;
	oct_t              oct_s1;
	logic              low_s1;
	logic              high_s1;
	logic              rdy_s1;

	// Stage 2: numerator and divisor
	logic              valid_s2;
	num_t              num_s2;
	den_t              den_s2;
	oct_t              oct_s2;
	logic              low_s2;
	logic              high_s2;
	logic              rdy_s2;

	// Divider stages
	logic              dv_valid_s [DIV_ST];
	num_t              dv_rem_s   [DIV_ST];
	den_t              dv_den_s   [DIV_ST];
	quo_t              dv_quo_s   [DIV_ST];
	oct_t              dv_oct_s   [DIV_ST];
	logic              dv_low_s   [DIV_ST];
	logic              dv_high_s  [DIV_ST];
	logic              dv_rdy     [DIV_ST];

	// Output register
	logic              rdy_out;

	// Octave thresholds, compared in parallel
	logic [OCT_CNT:0]  ge;
	oct_t              oct_d;

	always_comb begin
		for (int k = 0; k <= OCT_CNT; k++) begin
			ge[k] = THR_W'(freq_hz) >= (THR_W'(OCT_BASE) << k);
		end
	end

	// Pick the highest threshold reached, up to OCT_MAX
	always_comb begin
		oct_d = '0;
		for (int k = 1; k <= OCT_MAX; k++) begin
			if (ge[k]) begin
				oct_d = OCT_BITS'(k);
			end
		end
	end

	// Ready chain: a stage takes new data when empty or when it moves on
	assign rdy_out  = !out_valid || out_ready;
	assign rdy_s2   = !valid_s2 || dv_rdy[0];
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			freq_s1 <= freq_hz;
			oct_s1  <= oct_d;
			low_s1  <= !ge[0];
			high_s1 <= ge[OCT_CNT];
		end
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload: numerator 2N + f, divisor 2f
	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			num_s2  <= (NUM_W'(DAC_SCALE) << (NUM_SHIFT + int'(oct_s1))) + NUM_W'(freq_s1);
			den_s2  <= {freq_s1, 1'b0};
			oct_s2  <= oct_s1;
			low_s2  <= low_s1;
			high_s2 <= high_s1;
		end
	end

	// Divider pipeline: each stage resolves BITS_PER_ST quotient bits
	for (genvar j = 0; j < DIV_ST; j++) begin : g_div
		logic src_valid;
		num_t src_rem;
		den_t src_den;
		quo_t src_quo;
		oct_t src_oct;
		logic src_low;
		logic src_high;
		logic rdy_next;
		num_t rem_d;
		quo_t quo_d;
		cmp_t sub_sh;

		if (j == 0) begin : g_first
			assign src_valid = valid_s2;
			assign src_rem   = num_s2;
			assign src_den   = den_s2;
			assign src_quo   = '0;
			assign src_oct   = oct_s2;
			assign src_low   = low_s2;
			assign src_high  = high_s2;
		end else begin : g_next
			assign src_valid = dv_valid_s[j-1];
			assign src_rem   = dv_rem_s[j-1];
			assign src_den   = dv_den_s[j-1];
			assign src_quo   = dv_quo_s[j-1];
			assign src_oct   = dv_oct_s[j-1];
			assign src_low   = dv_low_s[j-1];
			assign src_high  = dv_high_s[j-1];
		end

		if (j == DIV_ST - 1) begin : g_last
			assign rdy_next = rdy_out;
		end else begin : g_mid
			assign rdy_next = dv_rdy[j+1];
		end

		assign dv_rdy[j] = !dv_valid_s[j] || rdy_next;

		// Compare and subtract the shifted divisor, shift in quotient bits
		always_comb begin
			rem_d  = src_rem;
			quo_d  = src_quo;
			sub_sh = '0;
			for (int t = 0; t < BITS_PER_ST; t++) begin
				sub_sh = CMP_W'(src_den) << (Q_BITS - 1 - j * BITS_PER_ST - t);
				if (CMP_W'(rem_d) >= sub_sh) begin
					rem_d = NUM_W'(CMP_W'(rem_d) - sub_sh);
					quo_d = {quo_d[Q_BITS-2:0], 1'b1};
				end else begin
					quo_d = {quo_d[Q_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s[j] <= 1'b0;
			end else if (dv_rdy[j]) begin
				dv_valid_s[j] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (dv_rdy[j] && src_valid) begin
				dv_rem_s[j]  <= rem_d;
				dv_den_s[j]  <= src_den;
				dv_quo_s[j]  <= quo_d;
				dv_oct_s[j]  <= src_oct;
				dv_low_s[j]  <= src_low;
				dv_high_s[j] <= src_high;
			end
		end
	end

	// Round result: fine code = DAC_CENTER - quotient, clamped to 0..DAC_MAX
	quo_t q_last;
	oct_t oct_res;
	dac_t dac_res;
	logic clamp_res;

	assign q_last = dv_quo_s[DIV_ST-1];

	always_comb begin
		oct_res   = dv_oct_s[DIV_ST-1];
		dac_res   = '0;
		clamp_res = dv_high_s[DIV_ST-1];
		if (dv_low_s[DIV_ST-1]) begin
			oct_res   = '0;
			clamp_res = 1'b1;
		end else if (q_last > Q_BITS'(DAC_CENTER)) begin
			clamp_res = 1'b1;
		end else if (q_last < Q_BITS'(DAC_MIN_Q)) begin
			dac_res   = DAC_BITS'(DAC_MAX);
			clamp_res = 1'b1;
		end else begin
			dac_res = DAC_BITS'(Q_BITS'(DAC_CENTER) - q_last);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rdy_out) begin
			out_valid <= dv_valid_s[DIV_ST-1];
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (rdy_out && dv_valid_s[DIV_ST-1]) begin
			octave   <= oct_res;
			dac_code <= dac_res;
			clamped  <= clamp_res;
		end
	end

	// Pack the control word
	assign control_word = {octave, dac_code, CW_PAD'(0)};

`ifndef SYNTHESIS
	// An empty output register frees the whole pipeline
	a_free_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low while output register is empty");

	// A new result only comes from a valid last divider stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(dv_valid_s[DIV_ST-1]))
		else $error("result appeared without a divider item");

	// An interior code with an unclamped octave is never flagged
	a_interior_unclamped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dac_code != '0 && dac_code != DAC_BITS'(DAC_MAX)
			&& octave != '0 && octave != OCT_BITS'(OCT_MAX)) |-> !clamped)
		else $error("clamp flag set on an interior result");
`endif

endmodule
`default_nettype wire
